>>> design/tmpd_pkg.sv
// tmpd_pkg: shared types, constants and the cathode pin table for the tube driver
// no dependencies; imported by every module of the block
package tmpd_pkg;

    localparam int DIGIT_W     = 4;
    localparam int COUNT_W     = 16;
    localparam int ENABLE_W    = 3;
    localparam int PAINT_TUBES = 6;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 16;

    localparam logic [DIGIT_W-1:0] BLANK_CODE = 4'hf;
    localparam logic [DIGIT_W-1:0] KEEP_NIB   = 4'hf;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_PAINT = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_PERIOD_TOP = 1'b0,
        REG_COMPARE    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [DIGIT_W-1:0]  mux_low;
        logic [DIGIT_W-1:0]  mux_high;
        logic [ENABLE_W-1:0] tube_enable;
        logic                frame_end;
    } t_result;

    localparam logic [DIGIT_W-1:0] PIN_TABLE [16] = '{
        4'd2, 4'd8, 4'd9, 4'd0, 4'd1, 4'd5, 4'd4, 4'd6,
        4'd7, 4'd3, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf
    };

    function automatic logic [DIGIT_W-1:0] pin_code(input logic [DIGIT_W-1:0] nib);
        return PIN_TABLE[nib];
    endfunction

endpackage

>>> design/tmpd_digit_store.sv
// tmpd_digit_store: cathode code registers for all tubes, split in a low and a high bank
// depends on tmpd_pkg (pin table, widths)
module tmpd_digit_store #(
    parameter int TUBE_COUNT = 6,
    parameter int PH_W       = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_paint,
    input  logic [7:0]                  i_digits_first,
    input  logic [7:0]                  i_digits_second,
    input  logic [7:0]                  i_digits_third,
    input  logic [PH_W-1:0]             i_phase,
    output logic [tmpd_pkg::DIGIT_W-1:0] o_code_low,
    output logic [tmpd_pkg::DIGIT_W-1:0] o_code_high
);
    import tmpd_pkg::*;

    localparam int PAIR_COUNT = TUBE_COUNT / 2;
    localparam int HI_COUNT   = TUBE_COUNT - PAIR_COUNT;
    localparam int HI_W       = (HI_COUNT > 1) ? $clog2(HI_COUNT) : 1;

    logic [IN_DATA_W-1:0] w_all;
    logic [DIGIT_W-1:0]   w_nib [TUBE_COUNT];
    logic [DIGIT_W-1:0]   r_low [PAIR_COUNT];
    logic [DIGIT_W-1:0]   r_high [HI_COUNT];

    assign w_all = {i_digits_first, i_digits_second, i_digits_third};

    // tube t takes nibble t counted from the top; tubes past the painted six stay blank
    for (genvar g = 0; g < TUBE_COUNT; g++) begin : g_nib
        if (g < PAINT_TUBES) begin : g_src
            assign w_nib[g] = w_all[IN_DATA_W-1-DIGIT_W*g -: DIGIT_W];
        end else begin : g_none
            assign w_nib[g] = KEEP_NIB;
        end
    end

    for (genvar g = 0; g < PAIR_COUNT; g++) begin : g_low
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_low[g] <= BLANK_CODE;
            end else if (i_paint && (w_nib[g] != KEEP_NIB)) begin
                r_low[g] <= pin_code(w_nib[g]);
            end
        end
    end

    for (genvar g = 0; g < HI_COUNT; g++) begin : g_high
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_high[g] <= BLANK_CODE;
            end else if (i_paint && (w_nib[PAIR_COUNT+g] != KEEP_NIB)) begin
                r_high[g] <= pin_code(w_nib[PAIR_COUNT+g]);
            end
        end
    end

    assign o_code_low  = r_low[i_phase];
    assign o_code_high = r_high[HI_W'(i_phase)];

endmodule

>>> design/tmpd_scan_ctrl.sv
// tmpd_scan_ctrl: pwm counter, scan phase, mux and enable registers, config registers
// depends on tmpd_pkg (t_result, t_cfg_idx, widths)
module tmpd_scan_ctrl #(
    parameter int TUBE_COUNT = 6,
    parameter int PH_W       = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  logic                          i_cfg_we,
    input  tmpd_pkg::t_cfg_idx            i_cfg_index,
    input  logic [tmpd_pkg::COUNT_W-1:0]  i_cfg_data,
    input  logic [tmpd_pkg::DIGIT_W-1:0]  i_code_low,
    input  logic [tmpd_pkg::DIGIT_W-1:0]  i_code_high,
    output logic [PH_W-1:0]               o_phase,
    output tmpd_pkg::t_result             o_result
);
    import tmpd_pkg::*;

    localparam int PAIR_COUNT = TUBE_COUNT / 2;

    logic [COUNT_W-1:0]  r_top, r_cmp, r_count, n_count;
    logic [PH_W-1:0]     r_phase, n_phase, w_p;
    logic [DIGIT_W-1:0]  r_mux_low, r_mux_high, n_mux_low, n_mux_high;
    logic [ENABLE_W-1:0] r_enable, n_enable;
    logic                n_frame, w_wrap, w_match, w_last;

    // a phase at or past the pair count is taken as pair zero
    assign w_p    = ({1'b0, r_phase} >= (PH_W+1)'(PAIR_COUNT)) ? '0 : r_phase;
    assign w_last = (w_p == PH_W'(PAIR_COUNT - 1));
    assign w_wrap = (r_count >= r_top);

    always_comb begin
        n_count    = r_count;
        n_phase    = r_phase;
        n_mux_low  = r_mux_low;
        n_mux_high = r_mux_high;
        n_enable   = r_enable;
        n_frame    = 1'b0;
        w_match    = 1'b0;
        if (i_tick) begin
            if (w_wrap) begin
                n_count    = '0;
                n_mux_low  = '0;
                n_mux_high = '0;
                n_enable   = '0;
            end else begin
                n_count = r_count + 1'b1;
            end
            w_match = (n_count == r_cmp);
            if (w_match) begin
                n_mux_low  = n_mux_low | i_code_low;
                n_mux_high = n_mux_high | i_code_high;
                // pairs past the third shift out of the enable field
                n_enable   = n_enable | (ENABLE_W'(1) << w_p);
                n_phase    = w_last ? '0 : w_p + 1'b1;
                n_frame    = w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top      <= COUNT_W'(2499);
            r_cmp      <= COUNT_W'(1249);
            r_count    <= '0;
            r_phase    <= '0;
            r_mux_low  <= '0;
            r_mux_high <= '0;
            r_enable   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PERIOD_TOP: r_top <= i_cfg_data;
                    REG_COMPARE:    r_cmp <= i_cfg_data;
                    default:        r_top <= r_top;
                endcase
            end
            r_count    <= n_count;
            r_phase    <= n_phase;
            r_mux_low  <= n_mux_low;
            r_mux_high <= n_mux_high;
            r_enable   <= n_enable;
        end
    end

    assign o_phase              = w_p;
    assign o_result.mux_low     = n_mux_low;
    assign o_result.mux_high    = n_mux_high;
    assign o_result.tube_enable = n_enable;
    assign o_result.frame_end   = n_frame;

endmodule

>>> design/tube_multiplex_pwm_driver.sv
// tube_multiplex_pwm_driver: top level, input register, result register and stream ports
// depends on tmpd_pkg, tmpd_digit_store, tmpd_scan_ctrl
//
//  channel   direction  signals                         contents
//  s_axis    in         tvalid tready tdata tuser       paint digits, command
//  m_axis    out        tvalid tready tdata tlast       mux nibbles, enables, frame end
//  cfg       in         i_cfg_valid o_cfg_ready index   period top, compare value
//
// one item per cycle unless the output stalls: an item sits in the input register,
// the counter compare and the register update run between it and the result register
// synchronous active-low reset; digit codes reset to blank, counter and phase to zero
// a stalled output holds its result while one more item waits in the input register
// config writes are always taken and apply to the next tick
module tube_multiplex_pwm_driver #(
    parameter int TUBE_COUNT = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] digits_first, [15:8] digits_second, [23:16] digits_third
    input  logic [tmpd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] command
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [3:0] mux_low, [7:4] mux_high, [10:8] tube_enable, [15:11] zero
    output logic [tmpd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  tmpd_pkg::t_cfg_idx               i_cfg_index,
    input  logic [tmpd_pkg::COUNT_W-1:0]     i_cfg_data
);
    import tmpd_pkg::*;

    localparam int PAIR_COUNT = TUBE_COUNT / 2;
    localparam int PH_W       = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

    logic                 r_in_valid, r_out_valid, w_step;
    t_cmd                 r_in_cmd;
    logic [IN_DATA_W-1:0] r_in_data;
    logic [PH_W-1:0]      w_phase;
    logic [DIGIT_W-1:0]   w_code_low, w_code_high;
    t_result              w_result, r_out;

    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
                r_out       <= w_result;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd  <= t_cmd'(s_axis_tuser);
            r_in_data <= s_axis_tdata;
        end
    end

    tmpd_digit_store #(
        .TUBE_COUNT (TUBE_COUNT),
        .PH_W       (PH_W)
    ) u_digit_store (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_paint         (w_step && (r_in_cmd == CMD_PAINT)),
        .i_digits_first  (r_in_data[7:0]),
        .i_digits_second (r_in_data[15:8]),
        .i_digits_third  (r_in_data[23:16]),
        .i_phase         (w_phase),
        .o_code_low      (w_code_low),
        .o_code_high     (w_code_high)
    );

    tmpd_scan_ctrl #(
        .TUBE_COUNT (TUBE_COUNT),
        .PH_W       (PH_W)
    ) u_scan_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_step && (r_in_cmd == CMD_TICK)),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_code_low  (w_code_low),
        .i_code_high (w_code_high),
        .o_phase     (w_phase),
        .o_result    (w_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.tube_enable, r_out.mux_high, r_out.mux_low};
    assign m_axis_tlast  = r_out.frame_end;

`ifndef SYNTHESIS
    // a frame ends only on a lit tick, so some pair is enabled
    a_frame_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[10:8] != 3'b000))
        else $error("frame end with no pair enabled");

    // with three pairs the frame end comes with the third pair lit
    a_frame_last_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> ((PAIR_COUNT != 3) || m_axis_tdata[10]))
        else $error("frame end without the last pair enabled");

    // a paint leaves the mux and enable outputs as they were
    a_paint_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && (r_in_cmd == CMD_PAINT) |=>
            (r_out.mux_low == $past(r_out.mux_low)) &&
            (r_out.mux_high == $past(r_out.mux_high)) &&
            (r_out.tube_enable == $past(r_out.tube_enable)) && !r_out.frame_end)
        else $error("paint changed the scan outputs");
`endif

endmodule

>>> tb/tube_multiplex_pwm_driver_tb.sv
// tube_multiplex_pwm_driver_tb: self-checking bench for the multiplexed tube driver
// drives paint and tick items and register writes, and checks every result against a
// cycle-free display predictor; depends on tmpd_pkg and tube_multiplex_pwm_driver
module tube_multiplex_pwm_driver_tb;
    import tmpd_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RAND_BLOCKS  = 30;
    localparam int BLOCK_ITEMS  = 25;
    localparam int MAX_REPORTS  = 10;
    localparam int PAIRS        = 3;

    // bcd digit to cathode pin code, ten and up blank
    localparam logic [3:0] CATHODE_OF [16] = '{
        4'd2, 4'd8, 4'd9, 4'd0, 4'd1, 4'd5, 4'd4, 4'd6,
        4'd7, 4'd3, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf, 4'hf
    };

    localparam t_result NOTHING_LIT = '0;

    typedef struct packed {
        logic        is_cfg;
        t_cfg_idx    reg_idx;
        logic [15:0] reg_data;
        t_cmd        cmd;
        logic [23:0] digits;    // {third, second, first}
        logic        lit;       // row carries its own expected result
        t_result     want;
    } t_plan_row;

    localparam int PLAN_LEN = 29;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        // straight out of reset: nothing lit, default top keeps the counter far from compare
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_PAINT, 24'hffffff, 1'b1, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b1, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_PAINT, 24'h452301, 1'b1, NOTHING_LIT},
        // top of zero with compare zero: one pair lit on every tick
        '{1'b1, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b1, REG_COMPARE,    16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        // nibbles ten to fourteen blank a tube, fifteen keeps it
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_PAINT, 24'hdebca6, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_PAINT, 24'h9f8f7f, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        // compare above top never lights anything
        '{1'b1, REG_COMPARE,    16'hffff, CMD_TICK, 24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b1, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b1, NOTHING_LIT},
        // largest top: counter climbs, compare zero not reached
        '{1'b1, REG_PERIOD_TOP, 16'hffff, CMD_TICK, 24'h000000, 1'b0, NOTHING_LIT},
        '{1'b1, REG_COMPARE,    16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b1, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b1, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b1, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b1, NOTHING_LIT},
        // top lowered under the running count: wraps on the next tick
        '{1'b1, REG_PERIOD_TOP, 16'd2, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_PAINT, 24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_TICK,  24'h000000, 1'b0, NOTHING_LIT},
        '{1'b0, REG_PERIOD_TOP, 16'd0, CMD_PAINT, 24'hffffff, 1'b0, NOTHING_LIT}
    };

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    s_axis_tvalid  = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata   = '0;
    logic                    s_axis_tuser   = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    i_cfg_valid    = 1'b0;
    logic                    o_cfg_ready;
    t_cfg_idx                i_cfg_index    = REG_PERIOD_TOP;
    logic [COUNT_W-1:0]      i_cfg_data     = '0;

    // expected result for directed rows that carry one
    logic                    lit_pending    = 1'b0;
    t_result                 lit_value      = '0;

    int unsigned src_idle_pct  = 0;
    int unsigned dst_stall_pct = 0;

    // predicted display state
    logic [15:0] top_now, compare_now, count_now;
    logic [1:0]  phase_now;
    logic [3:0]  codes_now [PAINT_TUBES];
    logic [3:0]  low_now, high_now;
    logic [2:0]  enables_now;

    t_result display_due [$];
    int mismatches  = 0;
    int paints      = 0;
    int ticks       = 0;
    int cfg_writes  = 0;
    int frames      = 0;
    int quiet_cycles = 0;

    tube_multiplex_pwm_driver #(
        .TUBE_COUNT(6)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // applies one item to the predicted state and returns what the outputs show after it
    function automatic t_result display_next(t_cmd cmd, logic [23:0] digits);
        t_result     r;
        logic [3:0]  nib;
        int unsigned p;
        r.frame_end = 1'b0;
        if (cmd == CMD_PAINT) begin
            for (int t = 0; t < PAINT_TUBES; t++) begin
                // even tube takes the high nibble of its byte
                nib = digits[8 * (t / 2) + ((t % 2 == 0) ? 4 : 0) +: 4];
                if (nib != KEEP_NIB)
                    codes_now[t] = CATHODE_OF[nib];
            end
        end else begin
            if (count_now >= top_now) begin
                count_now   = '0;
                low_now     = '0;
                high_now    = '0;
                enables_now = '0;
            end else begin
                count_now = count_now + 16'd1;
            end
            if (count_now == compare_now) begin
                p = (phase_now >= PAIRS) ? 0 : phase_now;
                low_now     = low_now | codes_now[p];
                high_now    = high_now | codes_now[p + PAIRS];
                enables_now = enables_now | (3'b001 << p);
                if (p == PAIRS - 1) begin
                    phase_now   = '0;
                    r.frame_end = 1'b1;
                end else begin
                    phase_now = 2'(p + 1);
                end
            end
        end
        r.mux_low     = low_now;
        r.mux_high    = high_now;
        r.tube_enable = enables_now;
        return r;
    endfunction

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            top_now     = 16'd2499;
            compare_now = 16'd1249;
            count_now   = '0;
            phase_now   = '0;
            low_now     = '0;
            high_now    = '0;
            enables_now = '0;
            for (int t = 0; t < PAINT_TUBES; t++)
                codes_now[t] = BLANK_CODE;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                if (i_cfg_index == REG_PERIOD_TOP)
                    top_now = i_cfg_data;
                else
                    compare_now = i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.mux_low     = m_axis_tdata[3:0];
                got.mux_high    = m_axis_tdata[7:4];
                got.tube_enable = m_axis_tdata[10:8];
                got.frame_end   = m_axis_tlast;
                if (m_axis_tlast)
                    frames++;
                if (display_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result transfer: tdata %h tlast %b",
                                 m_axis_tdata, m_axis_tlast);
                end else begin
                    want = display_due.pop_front();
                    if (got !== want || m_axis_tdata[15:11] !== 5'd0) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected low %h high %h en %b frame %b,",
                                     want.mux_low, want.mux_high, want.tube_enable,
                                     want.frame_end,
                                     " got low %h high %h en %b frame %b pad %h",
                                     got.mux_low, got.mux_high,
                                     got.tube_enable, got.frame_end, m_axis_tdata[15:11]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = display_next(t_cmd'(s_axis_tuser), s_axis_tdata);
                display_due.push_back(lit_pending ? lit_value : want);
                if (s_axis_tuser == CMD_PAINT)
                    paints++;
                else
                    ticks++;
            end
        end
    end

    // ends a hung run: counts cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, display_due.size());
            $display("tube_multiplex_pwm_driver_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(t_cmd cmd, logic [23:0] digits, logic lit, t_result want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= digits;
        s_axis_tuser  <= cmd;
        lit_pending   <= lit;
        lit_value     <= want;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // leaves the block idle: input stopped, every result back, pipeline empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (display_due.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int          n;
        logic [23:0] digits;
        logic [15:0] top_pick;
        logic [15:0] cmp_pick;
        t_cmd        cmd;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (PLAN[r]) begin
            if (PLAN[r].is_cfg) begin
                drain();
                write_reg(PLAN[r].reg_idx, PLAN[r].reg_data);
            end else begin
                send_item(PLAN[r].cmd, PLAN[r].digits, PLAN[r].lit, PLAN[r].want);
            end
        end

        for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
            drain();
            case (blk * 4 / RAND_BLOCKS)
                0:       begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1:       begin src_idle_pct = 59; dst_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  dst_stall_pct = 59; end
                default: begin src_idle_pct = 16; dst_stall_pct = 16; end
            endcase

            // mostly short periods so pairs get lit often; now and then a huge one
            n = $urandom_range(9);
            if (n == 0)
                top_pick = 16'($urandom_range(65535));
            else if (n == 1)
                top_pick = '0;
            else
                top_pick = 16'($urandom_range(8, 1));
            n = $urandom_range(9);
            if (n < 2 && top_pick != 16'hffff)
                cmp_pick = 16'($urandom_range(65535, top_pick + 1));
            else
                cmp_pick = 16'($urandom_range(top_pick));
            n = $urandom_range(4);
            if (n != 1)
                write_reg(REG_PERIOD_TOP, top_pick);
            if (n != 2)
                write_reg(REG_COMPARE, cmp_pick);

            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                cmd = ($urandom_range(3) == 0) ? CMD_PAINT : CMD_TICK;
                digits = 24'($urandom);
                if (cmd == CMD_PAINT && $urandom_range(4) != 0) begin
                    // mostly valid digits, some keeps and out-of-range nibbles
                    for (int t = 0; t < 6; t++) begin
                        n = $urandom_range(9);
                        digits[4 * t +: 4] = (n < 6) ? 4'($urandom_range(9)) :
                                             (n < 8) ? KEEP_NIB :
                                                       4'($urandom_range(14, 10));
                    end
                end
                send_item(cmd, digits, 1'b0, NOTHING_LIT);
            end
        end

        drain();
        repeat (6) @(negedge i_clk);

        $display("summary: %0d paint and %0d tick transfers, %0d register writes, %0d frame ends",
                 paints, ticks, cfg_writes, frames);
        $display("summary: free-running, sender gaps, receiver stalls and mixed idling; %0d errors",
                 mismatches);
        if (mismatches == 0 && display_due.size() == 0)
            $display("tube_multiplex_pwm_driver_tb OK");
        else
            $display("tube_multiplex_pwm_driver_tb NOT OK");
        $finish;
    end

endmodule

>>> tube_multiplex_pwm_driver.f
design/tmpd_pkg.sv
design/tmpd_digit_store.sv
design/tmpd_scan_ctrl.sv
design/tube_multiplex_pwm_driver.sv
tb/tube_multiplex_pwm_driver_tb.sv
